// ===== design/spfs_pkg.sv =====
// Shared types, op codes and run microcode for the SPI flash program sequencer.
// Used by spfs_front, spfs_queue, spfs_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spfs_pkg;

  localparam int PAGE_BYTES = 64;
  localparam int ID_BYTES   = 4;
  localparam int BC_W       = $clog2(((PAGE_BYTES > ID_BYTES) ? PAGE_BYTES : ID_BYTES) + 1);
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int RUN_MAX    = 16;
  localparam int STEP_W     = $clog2(RUN_MAX);

  // Item kinds on the func input
  localparam logic [1:0] F_CMD   = 2'd0;
  localparam logic [1:0] F_DATA  = 2'd1;
  localparam logic [1:0] F_REPLY = 2'd2;
  localparam logic [1:0] F_READY = 2'd3;

  // Host commands
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_PROGRAM = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_ID      = 2'd3;

  // SPI / host operation codes
  localparam logic [3:0] OP_SEL   = 4'd0;
  localparam logic [3:0] OP_DESEL = 4'd1;
  localparam logic [3:0] OP_SEND  = 4'd2;
  localparam logic [3:0] OP_XFER  = 4'd3;
  localparam logic [3:0] OP_HOST  = 4'd4;
  localparam logic [3:0] OP_PEND  = 4'd5;
  localparam logic [3:0] OP_PIN   = 4'd6;
  localparam logic [3:0] OP_ON    = 4'd7;
  localparam logic [3:0] OP_OFF   = 4'd8;
  localparam logic [3:0] OP_WANT  = 4'd9;
  localparam logic [3:0] OP_DONE  = 4'd10;

  // Flash command bytes
  localparam logic [7:0] FC_READ_ID = 8'h9f;
  localparam logic [7:0] FC_STATUS  = 8'h05;
  localparam logic [7:0] FC_READ    = 8'h03;
  localparam logic [7:0] FC_WREN    = 8'h06;
  localparam logic [7:0] FC_ERASE   = 8'hd8;
  localparam logic [7:0] FC_PROGRAM = 8'h02;

  // Run kinds: each names a fixed sequence of operations
  localparam logic [3:0] K_READ_CMD       = 4'd0;
  localparam logic [3:0] K_PROG_CMD       = 4'd1;
  localparam logic [3:0] K_DATA_FIRST     = 4'd2;
  localparam logic [3:0] K_DATA_FIRST_END = 4'd3;
  localparam logic [3:0] K_DATA           = 4'd4;
  localparam logic [3:0] K_DATA_END       = 4'd5;
  localparam logic [3:0] K_POLL_BUSY      = 4'd6;
  localparam logic [3:0] K_POLL_WANT      = 4'd7;
  localparam logic [3:0] K_POLL_FINISH    = 4'd8;
  localparam logic [3:0] K_HOST_XFER      = 4'd9;
  localparam logic [3:0] K_ID_END         = 4'd10;
  localparam logic [3:0] K_RD_PAGE_END    = 4'd11;
  localparam logic [3:0] K_RD_END         = 4'd12;
  localparam logic [3:0] K_ID_READY       = 4'd13;
  localparam logic [3:0] K_RD_READY       = 4'd14;

  // Byte source of one operation
  localparam logic [2:0] SRC_ZERO  = 3'd0;
  localparam logic [2:0] SRC_CONST = 3'd1;
  localparam logic [2:0] SRC_A2    = 3'd2;
  localparam logic [2:0] SRC_A1    = 3'd3;
  localparam logic [2:0] SRC_A0    = 3'd4;
  localparam logic [2:0] SRC_PAY   = 3'd5;

  typedef struct packed {
    logic [3:0]  kind;
    logic [23:0] addr;
    logic [7:0]  pay;
  } qent_t;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] src;
    logic [7:0] cval;
    logic       fin;
  } uop_t;

  function automatic uop_t uo(input logic [3:0] op, input logic [2:0] src,
                              input logic [7:0] cval);
    uop_t u;
    u.op   = op;
    u.src  = src;
    u.cval = cval;
    u.fin  = 1'b0;
    return u;
  endfunction

  function automatic uop_t run_step(input logic [3:0] kind, input logic [STEP_W-1:0] idx);
    uop_t [RUN_MAX-1:0] s;
    int n;
    s = '0;
    n = 1;
    unique case (kind)
      K_READ_CMD: begin
        s[0] = uo(OP_PIN, SRC_ZERO, 8'h00);
        s[1] = uo(OP_ON, SRC_ZERO, 8'h00);
        s[2] = uo(OP_SEL, SRC_ZERO, 8'h00);
        s[3] = uo(OP_SEND, SRC_CONST, FC_READ);
        s[4] = uo(OP_SEND, SRC_A2, 8'h00);
        s[5] = uo(OP_SEND, SRC_A1, 8'h00);
        s[6] = uo(OP_SEND, SRC_A0, 8'h00);
        n = 7;
      end
      K_PROG_CMD: begin
        s[0]  = uo(OP_PIN, SRC_ZERO, 8'h00);
        s[1]  = uo(OP_ON, SRC_ZERO, 8'h00);
        s[2]  = uo(OP_SEL, SRC_ZERO, 8'h00);
        s[3]  = uo(OP_SEND, SRC_CONST, FC_WREN);
        s[4]  = uo(OP_DESEL, SRC_ZERO, 8'h00);
        s[5]  = uo(OP_SEL, SRC_ZERO, 8'h00);
        s[6]  = uo(OP_SEND, SRC_CONST, FC_ERASE);
        s[7]  = uo(OP_SEND, SRC_A2, 8'h00);
        s[8]  = uo(OP_SEND, SRC_A1, 8'h00);
        s[9]  = uo(OP_SEND, SRC_A0, 8'h00);
        s[10] = uo(OP_DESEL, SRC_ZERO, 8'h00);
        s[11] = uo(OP_DESEL, SRC_ZERO, 8'h00);
        s[12] = uo(OP_SEL, SRC_ZERO, 8'h00);
        s[13] = uo(OP_SEND, SRC_CONST, FC_STATUS);
        s[14] = uo(OP_XFER, SRC_ZERO, 8'h00);
        n = 15;
      end
      K_DATA_FIRST, K_DATA_FIRST_END: begin
        s[0]  = uo(OP_SEL, SRC_ZERO, 8'h00);
        s[1]  = uo(OP_SEND, SRC_CONST, FC_WREN);
        s[2]  = uo(OP_DESEL, SRC_ZERO, 8'h00);
        s[3]  = uo(OP_SEL, SRC_ZERO, 8'h00);
        s[4]  = uo(OP_SEND, SRC_CONST, FC_PROGRAM);
        s[5]  = uo(OP_SEND, SRC_A2, 8'h00);
        s[6]  = uo(OP_SEND, SRC_A1, 8'h00);
        s[7]  = uo(OP_SEND, SRC_A0, 8'h00);
        s[8]  = uo(OP_SEND, SRC_PAY, 8'h00);
        s[9]  = uo(OP_DESEL, SRC_ZERO, 8'h00);
        s[10] = uo(OP_DESEL, SRC_ZERO, 8'h00);
        s[11] = uo(OP_SEL, SRC_ZERO, 8'h00);
        s[12] = uo(OP_SEND, SRC_CONST, FC_STATUS);
        s[13] = uo(OP_XFER, SRC_ZERO, 8'h00);
        n = (kind == K_DATA_FIRST_END) ? 14 : 9;
      end
      K_DATA, K_DATA_END: begin
        s[0] = uo(OP_SEND, SRC_PAY, 8'h00);
        s[1] = uo(OP_DESEL, SRC_ZERO, 8'h00);
        s[2] = uo(OP_DESEL, SRC_ZERO, 8'h00);
        s[3] = uo(OP_SEL, SRC_ZERO, 8'h00);
        s[4] = uo(OP_SEND, SRC_CONST, FC_STATUS);
        s[5] = uo(OP_XFER, SRC_ZERO, 8'h00);
        n = (kind == K_DATA_END) ? 6 : 1;
      end
      K_POLL_BUSY: begin
        s[0] = uo(OP_DESEL, SRC_ZERO, 8'h00);
        s[1] = uo(OP_SEL, SRC_ZERO, 8'h00);
        s[2] = uo(OP_SEND, SRC_CONST, FC_STATUS);
        s[3] = uo(OP_XFER, SRC_ZERO, 8'h00);
        n = 4;
      end
      K_POLL_WANT: begin
        s[0] = uo(OP_DESEL, SRC_ZERO, 8'h00);
        s[1] = uo(OP_WANT, SRC_ZERO, 8'h00);
        n = 2;
      end
      K_POLL_FINISH: begin
        s[0] = uo(OP_DESEL, SRC_ZERO, 8'h00);
        s[1] = uo(OP_OFF, SRC_ZERO, 8'h00);
        s[2] = uo(OP_PIN, SRC_CONST, 8'h01);
        s[3] = uo(OP_DONE, SRC_ZERO, 8'h00);
        n = 4;
      end
      K_HOST_XFER: begin
        s[0] = uo(OP_HOST, SRC_PAY, 8'h00);
        s[1] = uo(OP_XFER, SRC_ZERO, 8'h00);
        n = 2;
      end
      K_ID_END: begin
        s[0] = uo(OP_HOST, SRC_PAY, 8'h00);
        s[1] = uo(OP_DESEL, SRC_ZERO, 8'h00);
        s[2] = uo(OP_OFF, SRC_ZERO, 8'h00);
        s[3] = uo(OP_PIN, SRC_CONST, 8'h01);
        s[4] = uo(OP_PEND, SRC_ZERO, 8'h00);
        s[5] = uo(OP_DONE, SRC_ZERO, 8'h00);
        n = 6;
      end
      K_RD_PAGE_END, K_RD_END: begin
        s[0] = uo(OP_HOST, SRC_PAY, 8'h00);
        s[1] = uo(OP_PEND, SRC_ZERO, 8'h00);
        s[2] = uo(OP_DESEL, SRC_ZERO, 8'h00);
        s[3] = uo(OP_DESEL, SRC_ZERO, 8'h00);
        s[4] = uo(OP_SEL, SRC_ZERO, 8'h00);
        s[5] = uo(OP_SEND, SRC_CONST, FC_STATUS);
        s[6] = uo(OP_XFER, SRC_ZERO, 8'h00);
        n = (kind == K_RD_END) ? 7 : 2;
      end
      K_ID_READY: begin
        s[0] = uo(OP_PIN, SRC_ZERO, 8'h00);
        s[1] = uo(OP_ON, SRC_ZERO, 8'h00);
        s[2] = uo(OP_SEL, SRC_ZERO, 8'h00);
        s[3] = uo(OP_SEND, SRC_CONST, FC_READ_ID);
        s[4] = uo(OP_XFER, SRC_ZERO, 8'h00);
        n = 5;
      end
      K_RD_READY: begin
        s[0] = uo(OP_XFER, SRC_ZERO, 8'h00);
        n = 1;
      end
      default: begin
        s[0] = uo(OP_DONE, SRC_ZERO, 8'h00);
        n = 1;
      end
    endcase
    s[STEP_W'(n - 1)].fin = 1'b1;
    return s[idx];
  endfunction

endpackage

`default_nettype wire

// ===== design/spi_flash_program_sequencer.sv =====
// SPI NOR flash command sequencer: front end, run queue and op sequencer.
// An accepted item's run is written into the queue, then its first op into the output register.
// Throughput: one op per cycle from the sequencer unless out_ready stalls it; a run has
// 1 to 15 ops and ignored items push no run. A 4-entry run queue decouples input.
// Reset (rst, synchronous): idle mode, empty queue, no output pending.
`timescale 1ns / 1ps
`default_nettype none

module spi_flash_program_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [1:0]  command,
  input  wire logic [23:0] start_address,
  input  wire logic [23:0] byte_length,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  reply_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       op,
  output logic [7:0]       out_byte,
  output logic             last
);

  logic            q_full;
  logic            q_empty;
  logic            push;
  logic            pop;
  spfs_pkg::qent_t push_ent;
  spfs_pkg::qent_t head;

  spfs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .command       (command),
    .start_address (start_address),
    .byte_length   (byte_length),
    .data_byte     (data_byte),
    .reply_byte    (reply_byte),
    .q_full        (q_full),
    .push          (push),
    .push_ent      (push_ent)
  );

  spfs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  spfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .op        (op),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

`default_nettype wire

// ===== design/spfs_front.sv =====
// Front end: accepts items, tracks the flow state and classifies each item into a run kind.
// Depends on spfs_pkg; pushes run descriptors into spfs_queue.
`timescale 1ns / 1ps
`default_nettype none

module spfs_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         func,
  input  wire logic [1:0]         command,
  input  wire logic [23:0]        start_address,
  input  wire logic [23:0]        byte_length,
  input  wire logic [7:0]         data_byte,
  input  wire logic [7:0]         reply_byte,
  input  wire logic               q_full,
  output logic                    push,
  output spfs_pkg::qent_t         push_ent
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_PROG = 2'd1;
  localparam logic [1:0] M_READ = 2'd2;
  localparam logic [1:0] M_ID   = 2'd3;

  localparam logic [3:0] PH_NONE    = 4'd0;
  localparam logic [3:0] PH_ID_WAIT = 4'd1;
  localparam logic [3:0] PH_ID_READ = 4'd2;
  localparam logic [3:0] PH_RD_WAIT = 4'd3;
  localparam logic [3:0] PH_RD_DATA = 4'd4;
  localparam logic [3:0] PH_PG_DATA = 4'd5;
  localparam logic [3:0] PH_POLL    = 4'd6;

  localparam logic [1:0] AB_NONE    = 2'd0;
  localparam logic [1:0] AB_ERASE   = 2'd1;
  localparam logic [1:0] AB_PAGE    = 2'd2;

  localparam int BC_W = spfs_pkg::BC_W;

  logic [1:0]         mode, mode_next;
  logic [3:0]         phase, phase_next;
  logic [23:0]        cur_address, cur_address_next;
  logic signed [24:0] remaining, remaining_next;
  logic [BC_W-1:0]    byte_count, byte_count_next;
  logic [1:0]         after_busy, after_busy_next;

  logic               run;
  logic [3:0]         kind;
  logic [BC_W-1:0]    bc_inc;
  logic [23:0]        addr_adv;
  logic signed [24:0] rem_adv;
  logic               rem_done;
  logic               accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign bc_inc   = byte_count + BC_W'(1);
  assign addr_adv = cur_address + 24'(spfs_pkg::PAGE_BYTES);
  assign rem_adv  = remaining - 25'(spfs_pkg::PAGE_BYTES);
  assign rem_done = rem_adv[24] || (rem_adv == '0);

  always_comb begin
    mode_next        = mode;
    phase_next       = phase;
    cur_address_next = cur_address;
    remaining_next   = remaining;
    byte_count_next  = byte_count;
    after_busy_next  = after_busy;
    run              = 1'b0;
    kind             = spfs_pkg::K_RD_READY;
    unique case (func)
      spfs_pkg::F_CMD: begin
        if (mode == M_IDLE) begin
          if (command == spfs_pkg::CMD_ID) begin
            mode_next  = M_ID;
            phase_next = PH_ID_WAIT;
          end else if (command == spfs_pkg::CMD_READ || command == spfs_pkg::CMD_PROGRAM) begin
            run              = 1'b1;
            cur_address_next = start_address;
            remaining_next   = $signed({1'b0, byte_length});
            if (command == spfs_pkg::CMD_READ) begin
              kind       = spfs_pkg::K_READ_CMD;
              mode_next  = M_READ;
              phase_next = PH_RD_WAIT;
            end else begin
              kind            = spfs_pkg::K_PROG_CMD;
              mode_next       = M_PROG;
              phase_next      = PH_POLL;
              after_busy_next = AB_ERASE;
            end
          end
        end
      end
      spfs_pkg::F_DATA: begin
        if (mode == M_PROG && phase == PH_PG_DATA) begin
          run = 1'b1;
          if (bc_inc >= BC_W'(spfs_pkg::PAGE_BYTES)) begin
            kind = (byte_count == '0) ? spfs_pkg::K_DATA_FIRST_END : spfs_pkg::K_DATA_END;
            byte_count_next = '0;
            phase_next      = PH_POLL;
            after_busy_next = AB_PAGE;
          end else begin
            kind = (byte_count == '0) ? spfs_pkg::K_DATA_FIRST : spfs_pkg::K_DATA;
            byte_count_next = bc_inc;
          end
        end
      end
      spfs_pkg::F_REPLY: begin
        if (phase == PH_POLL) begin
          run = 1'b1;
          if (reply_byte[0]) begin
            kind = spfs_pkg::K_POLL_BUSY;
          end else if (after_busy == AB_ERASE ||
                       (after_busy == AB_PAGE && !rem_done)) begin
            // after the erase, or with more pages to go: ask the host for the next packet
            kind            = spfs_pkg::K_POLL_WANT;
            phase_next      = PH_PG_DATA;
            byte_count_next = '0;
            after_busy_next = AB_NONE;
            if (after_busy == AB_PAGE) begin
              cur_address_next = addr_adv;
              remaining_next   = rem_adv;
            end
          end else begin
            if (after_busy == AB_PAGE) begin
              cur_address_next = addr_adv;
              remaining_next   = rem_adv;
            end
            kind            = spfs_pkg::K_POLL_FINISH;
            mode_next       = M_IDLE;
            phase_next      = PH_NONE;
            after_busy_next = AB_NONE;
            byte_count_next = '0;
          end
        end else if (phase == PH_ID_READ) begin
          run = 1'b1;
          if (bc_inc < BC_W'(spfs_pkg::ID_BYTES)) begin
            kind            = spfs_pkg::K_HOST_XFER;
            byte_count_next = bc_inc;
          end else begin
            kind            = spfs_pkg::K_ID_END;
            mode_next       = M_IDLE;
            phase_next      = PH_NONE;
            byte_count_next = '0;
          end
        end else if (phase == PH_RD_DATA) begin
          run = 1'b1;
          if (bc_inc < BC_W'(spfs_pkg::PAGE_BYTES)) begin
            kind            = spfs_pkg::K_HOST_XFER;
            byte_count_next = bc_inc;
          end else begin
            byte_count_next  = '0;
            cur_address_next = addr_adv;
            remaining_next   = rem_adv;
            if (rem_done) begin
              kind            = spfs_pkg::K_RD_END;
              phase_next      = PH_POLL;
              after_busy_next = AB_NONE;
            end else begin
              kind       = spfs_pkg::K_RD_PAGE_END;
              phase_next = PH_RD_WAIT;
            end
          end
        end
      end
      spfs_pkg::F_READY: begin
        if (phase == PH_ID_WAIT) begin
          run             = 1'b1;
          kind            = spfs_pkg::K_ID_READY;
          phase_next      = PH_ID_READ;
          byte_count_next = '0;
        end else if (phase == PH_RD_WAIT) begin
          run             = 1'b1;
          kind            = spfs_pkg::K_RD_READY;
          phase_next      = PH_RD_DATA;
          byte_count_next = '0;
        end
      end
      default: begin
        run = 1'b0;
      end
    endcase
  end

  assign push          = accept && run;
  assign push_ent.kind = kind;
  assign push_ent.addr = cur_address_next;
  assign push_ent.pay  = (func == spfs_pkg::F_DATA) ? data_byte : reply_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      phase       <= PH_NONE;
      cur_address <= '0;
      remaining   <= '0;
      byte_count  <= '0;
      after_busy  <= AB_NONE;
    end else if (accept) begin
      mode        <= mode_next;
      phase       <= phase_next;
      cur_address <= cur_address_next;
      remaining   <= remaining_next;
      byte_count  <= byte_count_next;
      after_busy  <= after_busy_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/spfs_queue.sv =====
// Short FIFO of run descriptors between the front end and the op sequencer.
// Depends on spfs_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module spfs_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire spfs_pkg::qent_t  push_ent,
  input  wire logic             pop,
  output spfs_pkg::qent_t       head,
  output logic                  empty,
  output logic                  full
);

  localparam int QDEPTH = spfs_pkg::QDEPTH;
  localparam int QPTR_W = spfs_pkg::QPTR_W;
  localparam int QCNT_W = spfs_pkg::QCNT_W;

  spfs_pkg::qent_t   mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QDEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("run queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("run queue popped while empty");
`endif

endmodule

`default_nettype wire

// ===== design/spfs_back.sv =====
// Back end: steps through the ops of the run at the queue head, one per cycle unless
// stalled, into a registered output stage. Depends on spfs_pkg for the run microcode.
`timescale 1ns / 1ps
`default_nettype none

module spfs_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire spfs_pkg::qent_t  head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [3:0]            op,
  output logic [7:0]            out_byte,
  output logic                  last
);

  localparam int STEP_W = spfs_pkg::STEP_W;

  logic [STEP_W-1:0] idx;
  spfs_pkg::uop_t    u;
  logic              emit;
  logic [7:0]        byte_sel;

  assign u    = spfs_pkg::run_step(head.kind, idx);
  assign emit = !empty && (!out_valid || out_ready);
  assign pop  = emit && u.fin;

  always_comb begin
    unique case (u.src)
      spfs_pkg::SRC_CONST: byte_sel = u.cval;
      spfs_pkg::SRC_A2:    byte_sel = head.addr[23:16];
      spfs_pkg::SRC_A1:    byte_sel = head.addr[15:8];
      spfs_pkg::SRC_A0:    byte_sel = head.addr[7:0];
      spfs_pkg::SRC_PAY:   byte_sel = head.pay;
      default:             byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        idx       <= u.fin ? '0 : idx + STEP_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      op       <= u.op;
      out_byte <= byte_sel;
      last     <= u.fin;
    end
  end

`ifndef ASSERT_OFF
  a_idle_step_zero: assert property (@(posedge clk) disable iff (rst)
    empty |-> (idx == '0))
    else $error("step counter left mid-run with no run queued");

  a_step_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_valid && !out_ready) |=> (idx == $past(idx)))
    else $error("step counter moved while output stalled");
`endif

endmodule

`default_nettype wire
